### sv/rdpmm_pkg.sv
// Shared types and constants of the row dot-product matrix engine.
// Used by rdpmm_ctrl, rdpmm_dpath and the top level row_dot_product_matrix_multiply.
// Depends on nothing.
package rdpmm_pkg;

  // Default sizes of the element stores
  localparam int MAX_ROWS_A_DEF = 16;
  localparam int MAX_ROWS_B_DEF = 16;
  localparam int MAX_COLS_DEF   = 256;

  // Field widths
  localparam int MODE_W     = 2;
  localparam int ROW_W      = 4;
  localparam int COL_W      = 8;
  localparam int ELEM_W     = 16;
  localparam int PROD_W     = 2 * ELEM_W;
  localparam int DOT_W      = 40;
  localparam int ROWS_W     = 5;
  localparam int LEN_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  // Compare width for row indexes against row limits up to 2047
  localparam int ROW_CMP_W  = 11;

  // Register reset values
  localparam logic [ROWS_W-1:0] ROWS_A_RST  = 5'd16;
  localparam logic [ROWS_W-1:0] ROWS_B_RST  = 5'd16;
  localparam logic [LEN_W-1:0]  ROW_LEN_RST = 9'd256;

  // Item opcodes
  typedef enum logic [MODE_W-1:0] {
    MODE_WR_A = 2'd0,
    MODE_WR_B = 2'd1,
    MODE_CALC = 2'd2
  } mode_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A  = 2'd0,
    CFG_ROWS_B  = 2'd1,
    CFG_ROW_LEN = 2'd2
  } cfg_idx_e;

  // Result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_ROW = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic take;   // input channel open
    logic start;  // compute beat accepted: latch request
    logic issue;  // read one element pair
    logic load;   // move result into output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic calc_req;  // compute beat offered
    logic skip;      // offered compute has no element pairs to walk
    logic last_col;  // current read is the last column
    logic pipe_busy; // read or product still in flight
    logic out_free;  // output register can take a result
  } stat_t;

endpackage

### sv/row_dot_product_matrix_multiply.sv
// Top level of the row dot-product matrix engine (entry C[a][b] of A times B transposed).
// Depends on rdpmm_pkg, rdpmm_ctrl and rdpmm_dpath.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o): one beat carries mode, rows, column, element.
//   Mode write A / write B stores one Q1.15 element; no result follows.
//   Mode compute walks columns 0..len-1 of the two named rows, len = min(row_length,
//   MAX_COLS), one element pair per cycle through the two element RAMs and a single
//   multiply-accumulate. The 40-bit Q10.30 sum leaves on the output channel
//   (out_valid_o / out_stall_i) after the RAM read, product, accumulator and output
//   registers; a request naming a row past the configured rows returns status 1 and a
//   zero sum, and a zero length returns a zero sum as well. A compute occupies the
//   block until its result is loaded, so the block takes no new beat before that;
//   write beats go at one per cycle, also while a result waits in the output register.
//   If the receiver stalls, the result is held and a following compute finishes and
//   then waits until the output register is free.
//   Configuration (cfg_valid_i / cfg_ready_o, always ready) writes rows_a, rows_b,
//   row_length; write it only while no compute is in flight.
//   Reset clears control state and loads rows 16, 16 and length 256; the element
//   stores keep no reset value and must be written before they are read.
module row_dot_product_matrix_multiply #(
  parameter int MAX_ROWS_A = rdpmm_pkg::MAX_ROWS_A_DEF,
  parameter int MAX_ROWS_B = rdpmm_pkg::MAX_ROWS_B_DEF,
  parameter int MAX_COLS   = rdpmm_pkg::MAX_COLS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [rdpmm_pkg::MODE_W-1:0]        mode_i,
  input  logic [rdpmm_pkg::ROW_W-1:0]         row_a_i,
  input  logic [rdpmm_pkg::ROW_W-1:0]         row_b_i,
  input  logic [rdpmm_pkg::COL_W-1:0]         column_i,
  input  logic signed [rdpmm_pkg::ELEM_W-1:0] element_i,
  // configuration channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rdpmm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rdpmm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [rdpmm_pkg::DOT_W-1:0]  dot_value_o,
  output logic [rdpmm_pkg::ROW_W-1:0]         out_row_a_o,
  output logic [rdpmm_pkg::ROW_W-1:0]         out_row_b_o,
  output logic                                status_o
);

  rdpmm_pkg::cmd_t  cmd;
  rdpmm_pkg::stat_t st;

  assign in_stall_o  = ~cmd.take;
  assign cfg_ready_o = 1'b1;

  rdpmm_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .st_i  (st),
    .cmd_o (cmd)
  );

  rdpmm_dpath #(
    .MAX_ROWS_A(MAX_ROWS_A),
    .MAX_ROWS_B(MAX_ROWS_B),
    .MAX_COLS  (MAX_COLS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .row_a_i    (row_a_i),
    .row_b_i    (row_b_i),
    .column_i   (column_i),
    .element_i  (element_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .dot_value_o(dot_value_o),
    .out_row_a_o(out_row_a_o),
    .out_row_b_o(out_row_b_o),
    .status_o   (status_o),
    .cmd_i      (cmd),
    .st_o       (st)
  );

endmodule

### sv/rdpmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the element stores of the matrix engine. No package dependency.
module rdpmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/rdpmm_ctrl.sv
// Controller of the row dot-product matrix engine: sequences one compute request.
// Depends on rdpmm_pkg (cmd_t, stat_t).
module rdpmm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rdpmm_pkg::stat_t st_i,
  output rdpmm_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.take = 1'b1;
        if (st_i.calc_req) begin
          cmd_o.start = 1'b1;
          state_d     = st_i.skip ? ST_FLUSH : ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (st_i.last_col) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!st_i.pipe_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (st_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The accumulator must be final before the result is loaded
  a_done_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> !st_i.pipe_busy)
    else $error("result stage entered with products in flight");

  // A read issue must show up as pipeline activity
  a_issue_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |=> st_i.pipe_busy)
    else $error("issued read not tracked by pipeline");

endmodule

### sv/rdpmm_dpath.sv
// Datapath of the row dot-product matrix engine: config registers, element RAMs,
// multiply-accumulate pipeline and output register. Depends on rdpmm_pkg, rdpmm_ram.
module rdpmm_dpath #(
  parameter int MAX_ROWS_A = rdpmm_pkg::MAX_ROWS_A_DEF,
  parameter int MAX_ROWS_B = rdpmm_pkg::MAX_ROWS_B_DEF,
  parameter int MAX_COLS   = rdpmm_pkg::MAX_COLS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input channel payload
  input  logic                                  in_valid_i,
  input  logic [rdpmm_pkg::MODE_W-1:0]          mode_i,
  input  logic [rdpmm_pkg::ROW_W-1:0]           row_a_i,
  input  logic [rdpmm_pkg::ROW_W-1:0]           row_b_i,
  input  logic [rdpmm_pkg::COL_W-1:0]           column_i,
  input  logic signed [rdpmm_pkg::ELEM_W-1:0]   element_i,
  // configuration writes
  input  logic                                  cfg_valid_i,
  input  logic [rdpmm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [rdpmm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // output channel
  input  logic                                  out_stall_i,
  output logic                                  out_valid_o,
  output logic signed [rdpmm_pkg::DOT_W-1:0]    dot_value_o,
  output logic [rdpmm_pkg::ROW_W-1:0]           out_row_a_o,
  output logic [rdpmm_pkg::ROW_W-1:0]           out_row_b_o,
  output logic                                  status_o,
  // controller link
  input  rdpmm_pkg::cmd_t                       cmd_i,
  output rdpmm_pkg::stat_t                      st_o
);

  localparam int AwA   = $clog2(MAX_ROWS_A * MAX_COLS);
  localparam int AwB   = $clog2(MAX_ROWS_B * MAX_COLS);
  localparam int Cw    = $clog2(MAX_COLS + 1);
  localparam int CmpW  = (Cw > rdpmm_pkg::LEN_W) ? Cw : rdpmm_pkg::LEN_W;
  localparam int RcW   = rdpmm_pkg::ROW_CMP_W;
  localparam int DotW  = rdpmm_pkg::DOT_W;
  localparam int ProdW = rdpmm_pkg::PROD_W;

  // Configuration registers
  logic [rdpmm_pkg::ROWS_W-1:0] rows_a_q, rows_b_q;
  logic [rdpmm_pkg::LEN_W-1:0]  row_len_q;

  // Request registers
  logic [rdpmm_pkg::ROW_W-1:0] req_ra_q, req_rb_q;
  logic                        req_bad_q;
  logic [Cw-1:0]               len_q, col_q, col_nxt;
  logic [AwA-1:0]              base_a_q;
  logic [AwB-1:0]              base_b_q;

  // Pipeline
  logic                        rd_vld_q, prod_vld_q;
  logic [rdpmm_pkg::ELEM_W-1:0] a_rd, b_rd;
  logic signed [ProdW-1:0]     prod_q;
  logic [DotW-1:0]             acc_q;

  // Output register
  logic                        out_valid_q;
  logic [DotW-1:0]             dot_q;
  logic [rdpmm_pkg::ROW_W-1:0] out_ra_q, out_rb_q;
  logic                        status_q;

  // Decode of the offered beat
  logic           in_acc, is_wr_a, is_wr_b, is_calc;
  logic           bad_now;
  logic [Cw-1:0]  len_now;
  logic           we_a, we_b;
  logic [AwA-1:0] wr_addr_a, rd_addr_a;
  logic [AwB-1:0] wr_addr_b, rd_addr_b;

  assign in_acc  = in_valid_i & cmd_i.take;
  assign is_wr_a = (mode_i == rdpmm_pkg::MODE_WR_A);
  assign is_wr_b = (mode_i == rdpmm_pkg::MODE_WR_B);
  assign is_calc = (mode_i == rdpmm_pkg::MODE_CALC);

  // Row check against both the configured count and the store size
  assign bad_now = (RcW'(row_a_i) >= RcW'(rows_a_q)) || (RcW'(row_a_i) >= RcW'(MAX_ROWS_A)) ||
                   (RcW'(row_b_i) >= RcW'(rows_b_q)) || (RcW'(row_b_i) >= RcW'(MAX_ROWS_B));

  // Saturate the row length to the store width
  assign len_now = (CmpW'(row_len_q) > CmpW'(MAX_COLS)) ? Cw'(MAX_COLS) : Cw'(row_len_q);

  // Element writes: drop rows or columns outside the stores
  assign we_a = in_acc && is_wr_a && (RcW'(row_a_i) < RcW'(MAX_ROWS_A)) &&
                (CmpW'(column_i) < CmpW'(MAX_COLS));
  assign we_b = in_acc && is_wr_b && (RcW'(row_b_i) < RcW'(MAX_ROWS_B)) &&
                (CmpW'(column_i) < CmpW'(MAX_COLS));
  assign wr_addr_a = AwA'(AwA'(row_a_i) * AwA'(MAX_COLS)) + AwA'(column_i);
  assign wr_addr_b = AwB'(AwB'(row_b_i) * AwB'(MAX_COLS)) + AwB'(column_i);

  // Read addresses walk the two rows column by column
  assign rd_addr_a = base_a_q + AwA'(col_q);
  assign rd_addr_b = base_b_q + AwB'(col_q);
  assign col_nxt   = col_q + Cw'(1);

  rdpmm_ram #(
    .WIDTH(rdpmm_pkg::ELEM_W),
    .DEPTH(MAX_ROWS_A * MAX_COLS)
  ) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (we_a),
    .waddr_i(wr_addr_a),
    .wdata_i(element_i),
    .re_i   (cmd_i.issue),
    .raddr_i(rd_addr_a),
    .rdata_o(a_rd)
  );

  rdpmm_ram #(
    .WIDTH(rdpmm_pkg::ELEM_W),
    .DEPTH(MAX_ROWS_B * MAX_COLS)
  ) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (we_b),
    .waddr_i(wr_addr_b),
    .wdata_i(element_i),
    .re_i   (cmd_i.issue),
    .raddr_i(rd_addr_b),
    .rdata_o(b_rd)
  );

  // Configuration registers and control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= rdpmm_pkg::ROWS_A_RST;
      rows_b_q    <= rdpmm_pkg::ROWS_B_RST;
      row_len_q   <= rdpmm_pkg::ROW_LEN_RST;
      rd_vld_q    <= 1'b0;
      prod_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          rdpmm_pkg::CFG_ROWS_A:  rows_a_q  <= cfg_data_i[rdpmm_pkg::ROWS_W-1:0];
          rdpmm_pkg::CFG_ROWS_B:  rows_b_q  <= cfg_data_i[rdpmm_pkg::ROWS_W-1:0];
          rdpmm_pkg::CFG_ROW_LEN: row_len_q <= cfg_data_i[rdpmm_pkg::LEN_W-1:0];
          default: begin
          end
        endcase
      end
      rd_vld_q   <= cmd_i.issue;
      prod_vld_q <= rd_vld_q;
      // Hold the result until the receiver takes the beat
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request latch, column walk, multiply-accumulate and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_ra_q  <= row_a_i;
      req_rb_q  <= row_b_i;
      req_bad_q <= bad_now;
      len_q     <= len_now;
      col_q     <= '0;
      base_a_q  <= AwA'(AwA'(row_a_i) * AwA'(MAX_COLS));
      base_b_q  <= AwB'(AwB'(row_b_i) * AwB'(MAX_COLS));
    end else if (cmd_i.issue) begin
      col_q <= col_nxt;
    end
    if (rd_vld_q) begin
      prod_q <= $signed(a_rd) * $signed(b_rd);
    end
    if (cmd_i.start) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + {{(DotW - ProdW){prod_q[ProdW-1]}}, prod_q};
    end
    if (cmd_i.load) begin
      dot_q    <= req_bad_q ? '0 : acc_q;
      out_ra_q <= req_ra_q;
      out_rb_q <= req_rb_q;
      status_q <= req_bad_q ? rdpmm_pkg::STATUS_BAD_ROW : rdpmm_pkg::STATUS_OK;
    end
  end

  // Status to the controller
  assign st_o.calc_req  = in_valid_i & is_calc;
  assign st_o.skip      = bad_now || (len_now == '0);
  assign st_o.last_col  = (col_nxt == len_q);
  assign st_o.pipe_busy = rd_vld_q | prod_vld_q;
  assign st_o.out_free  = ~out_valid_q | ~out_stall_i;

  assign out_valid_o = out_valid_q;
  assign dot_value_o = $signed(dot_q);
  assign out_row_a_o = out_ra_q;
  assign out_row_b_o = out_rb_q;
  assign status_o    = status_q;

  // A rejected request never touches the element stores
  a_no_read_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> !req_bad_q)
    else $error("element read issued for an out-of-range request");

  // A pending result is never overwritten
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a stalled beat");

  // An error result carries a zero sum
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == rdpmm_pkg::STATUS_BAD_ROW)) |-> (dot_q == '0))
    else $error("error result with nonzero sum");

endmodule

### test/row_dot_product_matrix_multiply_tb.sv
// Self-checking testbench for row_dot_product_matrix_multiply: loads rows of A and B,
// requests dot products under several register settings and checks every entry.
// Depends on rdpmm_pkg and the row_dot_product_matrix_multiply RTL.
module row_dot_product_matrix_multiply_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rdpmm_pkg::*;

  localparam int NROWS = MAX_ROWS_A_DEF;
  localparam int NCOLS = MAX_COLS_DEF;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_BEATS = 30;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [ROW_W-1:0]         row_a;
    logic [ROW_W-1:0]         row_b;
    logic [COL_W-1:0]         column;
    logic signed [ELEM_W-1:0] element;
  } beat_t;

  typedef struct packed {
    logic signed [DOT_W-1:0] dot_value;
    logic [ROW_W-1:0]        row_a;
    logic [ROW_W-1:0]        row_b;
    logic                    status;
  } entry_t;

  // Mirror of both element stores and the registers; queue of entries still owed
  class entry_board;
    logic signed [ELEM_W-1:0] a_mem [NROWS][NCOLS];
    logic signed [ELEM_W-1:0] b_mem [NROWS][NCOLS];
    bit a_set [NROWS][NCOLS];
    bit b_set [NROWS][NCOLS];
    int unsigned rows_a;
    int unsigned rows_b;
    int unsigned row_len;
    entry_t pending[$];
    int errors;
    int checked;
    int bad_rows;

    function new();
      rows_a = ROWS_A_RST;
      rows_b = ROWS_B_RST;
      row_len = ROW_LEN_RST;
    endfunction

    function int unsigned lim_a();
      return rows_a < NROWS ? rows_a : NROWS;
    endfunction

    function int unsigned lim_b();
      return rows_b < MAX_ROWS_B_DEF ? rows_b : MAX_ROWS_B_DEF;
    endfunction

    function int unsigned span();
      return row_len < NCOLS ? row_len : NCOLS;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_ROWS_A:  rows_a = val[ROWS_W-1:0];
        CFG_ROWS_B:  rows_b = val[ROWS_W-1:0];
        CFG_ROW_LEN: row_len = val[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // Apply one accepted input beat; a compute owes one entry
    function void take_beat(beat_t bt);
      entry_t want;
      longint acc;
      case (bt.mode)
        MODE_WR_A: begin
          a_mem[bt.row_a][bt.column] = bt.element;
          a_set[bt.row_a][bt.column] = 1'b1;
        end
        MODE_WR_B: begin
          b_mem[bt.row_b][bt.column] = bt.element;
          b_set[bt.row_b][bt.column] = 1'b1;
        end
        MODE_CALC: begin
          want.row_a = bt.row_a;
          want.row_b = bt.row_b;
          want.status = (bt.row_a >= lim_a() || bt.row_b >= lim_b()) ?
                        STATUS_BAD_ROW : STATUS_OK;
          acc = 0;
          if (want.status == STATUS_OK) begin
            for (int c = 0; c < span(); c++)
              acc += longint'(a_mem[bt.row_a][c]) * longint'(b_mem[bt.row_b][c]);
          end else begin
            bad_rows++;
          end
          want.dot_value = acc[DOT_W-1:0];
          pending.push_back(want);
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted result beat with the oldest owed entry
    function void check_entry(entry_t got);
      entry_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected entry rows %0d/%0d dot %0d status %0b", $time,
                   got.row_a, got.row_b, got.dot_value, got.status);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.dot_value !== want.dot_value || got.row_a !== want.row_a ||
          got.row_b !== want.row_b || got.status !== want.status) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display({"%0t: entry mismatch: expected rows %0d/%0d dot %0d status %0b,",
                    " got rows %0d/%0d dot %0d status %0b"},
                   $time, want.row_a, want.row_b, want.dot_value, want.status,
                   got.row_a, got.row_b, got.dot_value, got.status);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [MODE_W-1:0] mode = MODE_WR_A;
  logic [ROW_W-1:0] row_a = '0;
  logic [ROW_W-1:0] row_b = '0;
  logic [COL_W-1:0] column = '0;
  logic signed [ELEM_W-1:0] element = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ROWS_A;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [DOT_W-1:0] dot_value;
  logic [ROW_W-1:0] out_row_a;
  logic [ROW_W-1:0] out_row_b;
  logic status;

  entry_board board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int beats_in = 0;
  int reg_writes = 0;

  row_dot_product_matrix_multiply uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .mode_i      (mode),
    .row_a_i     (row_a),
    .row_b_i     (row_b),
    .column_i    (column),
    .element_i   (element),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .dot_value_o (dot_value),
    .out_row_a_o (out_row_a),
    .out_row_b_o (out_row_b),
    .status_o    (status)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #1_000_000;
    $display("row_dot_product_matrix_multiply_tb: done, errors");
    $finish;
  end

  // Receiver: random stall, or one long hold-off when requested
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Check every result beat as it is taken
  always @(posedge clk) begin : take_result
    entry_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.dot_value = dot_value;
      seen.row_a = out_row_a;
      seen.row_b = out_row_b;
      seen.status = status;
      board.check_entry(seen);
    end
  end

  function automatic beat_t make_beat(logic [MODE_W-1:0] m, int ra, int rb, int col, int el);
    beat_t bt;
    bt.mode = m;
    bt.row_a = ra[ROW_W-1:0];
    bt.row_b = rb[ROW_W-1:0];
    bt.column = col[COL_W-1:0];
    bt.element = el[ELEM_W-1:0];
    return bt;
  endfunction

  // Bias elements toward the Q1.15 extremes and zero
  function automatic int rand_element();
    case ($urandom_range(0, 9))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // Offer one beat after a random gap; hold it until taken
  task automatic push_beat(input beat_t bt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    mode <= bt.mode;
    row_a <= bt.row_a;
    row_b <= bt.row_b;
    column <= bt.column;
    element <= bt.element;
    do @(posedge clk); while (in_stall);
    board.take_beat(bt);
    beats_in++;
  endtask

  // Drop valid, wait for every owed entry, then let the block go quiet
  task automatic settle(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val[CFG_DATA_W-1:0]);
    reg_writes++;
  endtask

  task automatic set_config(input int ra, input int rb, input int len);
    cfg_write(CFG_ROWS_A, ra);
    cfg_write(CFG_ROWS_B, rb);
    cfg_write(CFG_ROW_LEN, len);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic: writes, computes on loaded rows or out-of-range rows, some unused-mode noise
  task automatic run_random(input int beats, input bit pause_mid);
    int done;
    int pick;
    int ra;
    int rb;
    int col;
    done = 0;
    while (done < beats) begin
      pick = $urandom_range(0, 99);
      if (pause_mid && done >= beats / 2) begin
        settle(SETTLE_CYCLES);
        pause_mid = 1'b0;
      end
      if (pick < 6) begin
        push_beat(make_beat(MODE_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                            $urandom_range(0, 255), rand_element()));
      end else if (pick < 50) begin
        col = (board.span() > 0 && $urandom_range(0, 3) != 0) ?
              $urandom_range(0, board.span() - 1) : $urandom_range(0, 255);
        push_beat(make_beat(pick < 28 ? MODE_WR_A : MODE_WR_B, $urandom_range(0, 15),
                            $urandom_range(0, 15), col, rand_element()));
        done++;
      end else begin
        if ($urandom_range(0, 1) && board.lim_a() > 0 && board.lim_b() > 0) begin
          ra = $urandom_range(0, board.lim_a() - 1);
          rb = $urandom_range(0, board.lim_b() - 1);
        end else begin
          ra = $urandom_range(0, 15);
          rb = $urandom_range(0, 15);
        end
        if (ra < board.lim_a() && rb < board.lim_b()) begin
          if (board.span() > 64) begin
            // long rows: stay on the last rows, loaded in full at the start
            ra = NROWS - 1;
            rb = NROWS - 1;
          end else begin
            // load any column the compute would read that was never written
            for (int c = 0; c < board.span(); c++) begin
              if (!board.a_set[ra][c]) begin
                push_beat(make_beat(MODE_WR_A, ra, rb, c, rand_element()));
                done++;
              end
              if (!board.b_set[rb][c]) begin
                push_beat(make_beat(MODE_WR_B, ra, rb, c, rand_element()));
                done++;
              end
            end
          end
        end
        push_beat(make_beat(MODE_CALC, ra, rb, $urandom_range(0, 255), rand_element()));
        done++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 27;
    recv_idle_pct = 74;

    // Load the last row of A and B with the most negative element: largest sum
    for (int c = 0; c < NCOLS; c++) begin
      push_beat(make_beat(MODE_WR_A, NROWS - 1, 0, c, -32768));
      push_beat(make_beat(MODE_WR_B, 0, NROWS - 1, c, -32768));
    end
    push_beat(make_beat(MODE_CALC, 15, 15, 0, 0));
    push_beat(make_beat(MODE_WR_A, 15, 0, 255, 32767));
    push_beat(make_beat(MODE_WR_A, 0, 15, 0, -32768));
    push_beat(make_beat(MODE_WR_B, 15, 0, 0, 32767));
    push_beat(make_beat(MODE_WR_B, 0, 0, 255, 0));
    push_beat(make_beat(MODE_UNUSED, 15, 15, 255, 32767));
    push_beat(make_beat(MODE_CALC, 15, 15, 255, -1));
    settle(SETTLE_CYCLES);

    // Zero length, single row of A
    set_config(1, 16, 0);
    push_beat(make_beat(MODE_CALC, 0, 15, 0, 0));
    push_beat(make_beat(MODE_CALC, 1, 15, 0, 0));
    push_beat(make_beat(MODE_CALC, 0, 0, 0, 0));
    settle(SETTLE_CYCLES);

    // No rows of B: every compute fails; oversized length
    set_config(16, 0, 511);
    push_beat(make_beat(MODE_CALC, 15, 15, 0, 0));
    push_beat(make_beat(MODE_CALC, 0, 0, 0, 0));
    settle(SETTLE_CYCLES);

    // Rows and length past their maximum saturate
    set_config(31, 17, 257);
    push_beat(make_beat(MODE_CALC, 15, 15, 0, 0));
    settle(SETTLE_CYCLES);

    // Length one, two rows each, edges of the row limits
    set_config(2, 2, 1);
    push_beat(make_beat(MODE_WR_A, 1, 0, 0, 32767));
    push_beat(make_beat(MODE_WR_B, 0, 1, 0, 32767));
    push_beat(make_beat(MODE_CALC, 1, 1, 0, 0));
    push_beat(make_beat(MODE_CALC, 0, 1, 0, 0));
    push_beat(make_beat(MODE_CALC, 2, 1, 0, 0));
    push_beat(make_beat(MODE_CALC, 1, 2, 0, 0));
    push_beat(make_beat(MODE_CALC, 0, 0, 0, 0));
    settle(SETTLE_CYCLES);

    // Random phases; long lengths keep both row limits at sixteen
    for (int p = 0; p < 10; p++) begin
      if (p < 3) begin
        send_idle_pct = 27;
        recv_idle_pct = 74;
      end else if (p < 6) begin
        send_idle_pct = 74;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: set_config(16, 16, 8);
        1: set_config(3, 5, 16);
        2: set_config(16, 16, 256);
        3: set_config(1, 1, 1);
        4: set_config(8, 12, 24);
        5: set_config(31, 20, 300);
        6: set_config(16, 16, 4);
        7: set_config(2, 16, 12);
        8: set_config(16, 16, 100);
        default: set_config(16, 16, 32);
      endcase
      if (p == 0) hold_req = 1'b1;
      run_random(PHASE_BEATS, p == 4);
      settle(p == 9 ? TAIL_CYCLES : SETTLE_CYCLES);
    end

    $display("covered %0d input beats and %0d register writes over fifteen settings;",
             beats_in, reg_writes);
    $display("checked %0d entries, %0d of them bad-row, %0d mismatches, %0d still owed",
             board.checked, board.bad_rows, board.errors, board.pending.size());
    if (board.errors == 0 && board.pending.size() == 0)
      $display("row_dot_product_matrix_multiply_tb: done, clean");
    else
      $display("row_dot_product_matrix_multiply_tb: done, errors");
    $finish;
  end

endmodule
